/* sv/pow_difficulty_retarget_defines.svh */
// Assertion macros for the difficulty retarget block
`ifndef POW_DIFFICULTY_RETARGET_DEFINES_SVH
`define POW_DIFFICULTY_RETARGET_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define PDR_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// consequent must hold whenever the antecedent holds
`define PDR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* sv/pdr_pkg.sv */
// Shared constants and types for the difficulty retarget block
`timescale 1ns / 1ps
`default_nettype none
package pdr_pkg;
    localparam int DIFF_W        = 48;
    localparam int HEIGHT_W      = 32;
    localparam int LEN_W         = 16;
    localparam int SPAN_W        = 40;
    localparam int CFG_IDX_W     = 2;
    localparam int CHUNK_W       = 16;
    localparam int TIME_BITS_DEF = 40;
    localparam int FRAC_BITS_DEF = 24;
    localparam int PB_SHIFT      = 11;

    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};
    localparam logic [13:0]       PB_DIV   = 14'd10000;
    localparam logic [11:0]       PB_BASE  = 12'd2049;
    localparam logic [11:0]       PB_FLOOR = 12'd1949;
    localparam logic [6:0]        PB_QCAP  = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 2'd0,
        CFG_DYN  = 2'd1,
        CFG_LEN  = 2'd2,
        CFG_SPAN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [DIFF_W-1:0] diff;
        logic              h_zero;
        logic              clamp_up;
        logic              clamp_dn;
        logic              neg;
        logic              uncle;
    } t_side;
endpackage
`default_nettype wire

/* sv/pdr_front.sv */
// Front stages: span checks, partial products, divider operand select
`timescale 1ns / 1ps
`default_nettype none
module pdr_front import pdr_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int QW        = 50
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_ce,
    input  wire logic                 i_valid,
    input  wire logic [HEIGHT_W-1:0]  i_height,
    input  wire logic [TIME_BITS-1:0] i_tip,
    input  wire logic [DIFF_W-1:0]    i_diff,
    input  wire logic [TIME_BITS-1:0] i_start,
    input  wire logic [TIME_BITS-1:0] i_par,
    input  wire logic                 i_uncle,
    input  wire logic                 i_mode,
    input  wire logic [SPAN_W-1:0]    i_span,
    output logic                      o_valid,
    output t_side                     o_side,
    output logic [TIME_BITS-1:0]      o_rem,
    output logic [QW-1:0]             o_num,
    output logic [TIME_BITS-1:0]      o_div,
    output logic [QW-1:0]             o_hnum
);
    localparam int PP_N  = (TIME_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int PP_W  = DIFF_W + CHUNK_W;
    localparam int NUM_W = DIFF_W + TIME_BITS;
    localparam int SUM_W = DIFF_W + PP_N * CHUNK_W;

    logic [TIME_BITS-1:0]        t_span;
    logic [PP_N*CHUNK_W-1:0]     t_pad;
    logic [TIME_BITS-1:0]        s_span;
    logic                        le, eq, c4, cq;
    logic                        neg;
    logic [TIME_BITS-1:0]        mag;

    logic                        r_valid, n_valid;
    t_side                       r_side, n_side;
    logic [PP_W-1:0]             r_pp [PP_N];
    logic [TIME_BITS-1:0]        r_s, r_mag;
    logic [HEIGHT_W-1:0]         r_height;

    logic [SUM_W-1:0]            sum;
    logic [NUM_W-1:0]            numer;

    assign t_span = TIME_BITS'(i_span);
    assign t_pad  = (PP_N*CHUNK_W)'(t_span);
    assign s_span = i_tip - i_start;
    assign le     = i_tip <= i_start;
    assign eq     = i_tip == i_start;
    assign c4     = (t_span != '0) && (s_span <= ((t_span - 1'b1) >> 2));
    assign cq     = t_span <= ((s_span - 1'b1) >> 2);
    assign neg    = i_tip < i_par;
    assign mag    = neg ? (i_par - i_tip) : (i_tip - i_par);

    always_comb begin
        n_valid         = i_valid;
        n_side.diff     = i_diff;
        n_side.h_zero   = i_height == '0;
        n_side.clamp_up = le ? eq : c4;
        n_side.clamp_dn = le ? !eq : (!c4 && cq);
        n_side.neg      = neg;
        n_side.uncle    = i_uncle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_side   <= n_side;
            r_s      <= s_span;
            r_mag    <= mag;
            r_height <= i_height;
            for (int k = 0; k < PP_N; k++) begin
                r_pp[k] <= PP_W'(i_diff * t_pad[k*CHUNK_W +: CHUNK_W]);
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < PP_N; k++) begin
            sum = sum + (SUM_W'(r_pp[k]) << (k * CHUNK_W));
        end
        numer = i_mode ? NUM_W'(r_mag) : NUM_W'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ce) begin
            o_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_side <= r_side;
            o_rem  <= TIME_BITS'(numer >> QW);
            o_num  <= numer[QW-1:0];
            o_div  <= i_mode ? TIME_BITS'(PB_DIV) : r_s;
            o_hnum <= QW'(r_height);
        end
    end
endmodule
`default_nettype wire

/* sv/pdr_cell.sv */
// Divider cell: one quotient bit of the main lane and one step of the modulo lane
`timescale 1ns / 1ps
`default_nettype none
module pdr_cell import pdr_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int QW        = 50
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_ce,
    input  wire logic                 i_valid,
    input  wire t_side                i_side,
    input  wire logic [TIME_BITS-1:0] i_rem,
    input  wire logic [QW-1:0]        i_num,
    input  wire logic [TIME_BITS-1:0] i_div,
    input  wire logic [LEN_W-1:0]     i_mrem,
    input  wire logic [QW-1:0]        i_hnum,
    input  wire logic [LEN_W-1:0]     i_len,
    output logic                      o_valid,
    output t_side                     o_side,
    output logic [TIME_BITS-1:0]      o_rem,
    output logic [QW-1:0]             o_num,
    output logic [TIME_BITS-1:0]      o_div,
    output logic [LEN_W-1:0]          o_mrem,
    output logic [QW-1:0]             o_hnum
);
    logic [TIME_BITS:0] sh;
    logic               ge;
    logic [LEN_W:0]     msh;
    logic               mge;

    assign sh  = {i_rem, i_num[QW-1]};
    assign ge  = sh >= {1'b0, i_div};
    assign msh = {i_mrem, i_hnum[QW-1]};
    assign mge = msh >= {1'b0, i_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ce) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_side <= i_side;
            o_rem  <= ge ? TIME_BITS'(sh - {1'b0, i_div}) : TIME_BITS'(sh);
            o_num  <= {i_num[QW-2:0], ge};
            o_div  <= i_div;
            o_mrem <= mge ? LEN_W'(msh - {1'b0, i_len}) : LEN_W'(msh);
            o_hnum <= {i_hnum[QW-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

/* sv/pdr_back.sv */
// Back stages: per-block multiply, result select, saturation and output register
`timescale 1ns / 1ps
`default_nettype none
module pdr_back import pdr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int QW        = 50
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_ce,
    input  wire logic              i_valid,
    input  wire t_side             i_side,
    input  wire logic [QW-1:0]     i_q,
    input  wire logic [LEN_W-1:0]  i_mrem,
    input  wire logic              i_mode,
    input  wire logic              i_dyn,
    input  wire logic [LEN_W-1:0]  i_len,
    output logic                   o_valid,
    output logic [DIFF_W-1:0]      o_next,
    output logic                   o_clamp
);
    localparam logic [DIFF_W-1:0] ONE_Q = DIFF_W'(1) << FRAC_BITS;
    localparam logic [DIFF_W-1:0] MIN_Q = (ONE_Q + DIFF_W'(5)) / DIFF_W'(10);
    localparam int MW    = QW + 2;
    localparam int MPP_N = (MW + CHUNK_W - 1) / CHUNK_W;
    localparam int PP_W  = DIFF_W + CHUNK_W;
    localparam int SUM_W = DIFF_W + MPP_N * CHUNK_W;

    logic [MW-1:0]          m;
    logic [MPP_N*CHUNK_W-1:0] m_pad;
    logic [DIFF_W-1:0]      q_sat, up_sat, scaled, ep_next;
    logic                   retarget;

    logic                   r_valid;
    logic                   r_h_zero;
    logic [DIFF_W-1:0]      r_ep_next;
    logic                   r_ep_clamp;
    logic [PP_W-1:0]        r_pp [MPP_N];

    logic [SUM_W-1:0]       sum;
    logic [SUM_W-1:0]       shifted;
    logic [DIFF_W-1:0]      pb, n_next;

    always_comb begin
        if (i_side.neg) begin
            m = MW'(PB_BASE) + MW'(i_q);
        end else if (i_q >= QW'(PB_QCAP)) begin
            m = MW'(PB_FLOOR);
        end else begin
            m = MW'(PB_BASE) - MW'(i_q);
        end
        m     = m + MW'(i_side.uncle);
        m_pad = (MPP_N*CHUNK_W)'(m);
    end

    assign q_sat   = (i_q > QW'(DIFF_MAX)) ? DIFF_MAX : DIFF_W'(i_q);
    assign up_sat  = (i_side.diff[DIFF_W-1 -: 2] != 2'b00) ? DIFF_MAX : (i_side.diff << 2);
    assign scaled  = i_side.clamp_up ? up_sat : (i_side.clamp_dn ? (i_side.diff >> 2) : q_sat);
    assign ep_next = i_dyn ? scaled : ONE_Q;
    assign retarget = (i_len != '0) && (i_mrem == '0) && !i_side.h_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_h_zero   <= i_side.h_zero;
            r_ep_next  <= i_side.h_zero ? ONE_Q : (retarget ? ep_next : i_side.diff);
            r_ep_clamp <= retarget && (i_side.clamp_up || i_side.clamp_dn);
            for (int k = 0; k < MPP_N; k++) begin
                r_pp[k] <= PP_W'(i_side.diff * m_pad[k*CHUNK_W +: CHUNK_W]);
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < MPP_N; k++) begin
            sum = sum + (SUM_W'(r_pp[k]) << (k * CHUNK_W));
        end
        shifted = sum >> PB_SHIFT;
        pb      = (shifted > SUM_W'(DIFF_MAX)) ? DIFF_MAX : DIFF_W'(shifted);
        if (pb < MIN_Q) begin
            pb = MIN_Q;
        end
        n_next = i_mode ? (r_h_zero ? ONE_Q : pb) : r_ep_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ce) begin
            o_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_next  <= n_next;
            o_clamp <= !i_mode && r_ep_clamp;
        end
    end
endmodule
`default_nettype wire

/* sv/pow_difficulty_retarget.sv */
// Path: each input beat goes through the front stages, the row of divider cells and the back stages.
// Throughput: one beat per cycle; the row of divider cells is fully pipelined,
// one quotient bit per cell, and the whole pipe advances when the output is free.
// Reset (synchronous, active low) empties the pipe and loads the register defaults:
// epoch mode, dynamic on, epoch length 2016, target span 1209600000 ms.
`timescale 1ns / 1ps
`default_nettype none
`include "pow_difficulty_retarget_defines.svh"
module pow_difficulty_retarget import pdr_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tip_height, tip_time_ms, tip_difficulty, epoch_start_ms, parent_time_ms, zero pad
    input  wire logic [((HEIGHT_W + DIFF_W + 3*TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // uncle_seen
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // next_difficulty
    output logic [DIFF_W-1:0]          m_axis_tdata,
    // ratio_clamped
    output logic                       m_axis_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [SPAN_W-1:0]     i_cfg_data
);
    localparam int QW = (TIME_BITS - 13 > 50) ? (TIME_BITS - 13) : 50;
    localparam int O_TIP   = HEIGHT_W;
    localparam int O_DIFF  = O_TIP + TIME_BITS;
    localparam int O_START = O_DIFF + DIFF_W;
    localparam int O_PAR   = O_START + TIME_BITS;
    localparam logic [DIFF_W-1:0] MIN_Q =
        ((DIFF_W'(1) << FRAC_BITS) + DIFF_W'(5)) / DIFF_W'(10);

    logic              r_mode, r_dyn;
    logic [LEN_W-1:0]  r_len;
    logic [SPAN_W-1:0] r_span;
    logic              ce;

    logic                 c_valid [QW+1];
    t_side                c_side  [QW+1];
    logic [TIME_BITS-1:0] c_rem   [QW+1];
    logic [QW-1:0]        c_num   [QW+1];
    logic [TIME_BITS-1:0] c_div   [QW+1];
    logic [LEN_W-1:0]     c_mrem  [QW+1];
    logic [QW-1:0]        c_hnum  [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_dyn  <= 1'b1;
            r_len  <= LEN_W'(2016);
            r_span <= SPAN_W'(1209600000);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE: r_mode <= i_cfg_data[0];
                CFG_DYN:  r_dyn  <= i_cfg_data[0];
                CFG_LEN:  r_len  <= i_cfg_data[LEN_W-1:0];
                CFG_SPAN: r_span <= i_cfg_data;
                default:  r_mode <= r_mode;
            endcase
        end
    end

    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    pdr_front #(.TIME_BITS(TIME_BITS), .QW(QW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (s_axis_tvalid),
        .i_height (s_axis_tdata[HEIGHT_W-1:0]),
        .i_tip    (s_axis_tdata[O_TIP +: TIME_BITS]),
        .i_diff   (s_axis_tdata[O_DIFF +: DIFF_W]),
        .i_start  (s_axis_tdata[O_START +: TIME_BITS]),
        .i_par    (s_axis_tdata[O_PAR +: TIME_BITS]),
        .i_uncle  (s_axis_tuser),
        .i_mode   (r_mode),
        .i_span   (r_span),
        .o_valid  (c_valid[0]),
        .o_side   (c_side[0]),
        .o_rem    (c_rem[0]),
        .o_num    (c_num[0]),
        .o_div    (c_div[0]),
        .o_hnum   (c_hnum[0])
    );

    assign c_mrem[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        pdr_cell #(.TIME_BITS(TIME_BITS), .QW(QW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (c_valid[g]),
            .i_side  (c_side[g]),
            .i_rem   (c_rem[g]),
            .i_num   (c_num[g]),
            .i_div   (c_div[g]),
            .i_mrem  (c_mrem[g]),
            .i_hnum  (c_hnum[g]),
            .i_len   (r_len),
            .o_valid (c_valid[g+1]),
            .o_side  (c_side[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_num   (c_num[g+1]),
            .o_div   (c_div[g+1]),
            .o_mrem  (c_mrem[g+1]),
            .o_hnum  (c_hnum[g+1])
        );
    end

    pdr_back #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (c_valid[QW]),
        .i_side  (c_side[QW]),
        .i_q     (c_num[QW]),
        .i_mrem  (c_mrem[QW]),
        .i_mode  (r_mode),
        .i_dyn   (r_dyn),
        .i_len   (r_len),
        .o_valid (m_axis_tvalid),
        .o_next  (m_axis_tdata),
        .o_clamp (m_axis_tuser)
    );

    `PDR_ASSERT_IMPL(a_pb_floor, i_clk, i_rst_n, m_axis_tvalid && r_mode, m_axis_tdata >= MIN_Q)
    `PDR_ASSERT_IMPL(a_clamp_epoch, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, !r_mode)
    `PDR_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
endmodule
`default_nettype wire

/* sim/tb_pow_difficulty_retarget.sv */
// Self-checking testbench for the difficulty retarget block: directed table plus random phases
`timescale 1ns / 1ps
`default_nettype none
module tb_pow_difficulty_retarget;
    import pdr_pkg::*;

    localparam int TW      = 40;
    localparam int DW      = HEIGHT_W + DIFF_W + 3*TW;
    localparam int LIMIT   = 5000;
    localparam int HOLD    = 600;
    localparam int PHASES  = 10;
    localparam int PER_PH  = 190;
    localparam logic [DIFF_W-1:0] ONE_Q = 48'd1 << 24;
    localparam logic [DIFF_W-1:0] MIN_Q = 48'd1677722;
    localparam logic [TW-1:0]     TMAX  = {TW{1'b1}};
    localparam logic [SPAN_W-1:0] RSPAN = 40'd1209600000;

    typedef struct packed {
        logic [TW-1:0]       parent;
        logic [TW-1:0]       start;
        logic [DIFF_W-1:0]   diff;
        logic [TW-1:0]       tip;
        logic [HEIGHT_W-1:0] height;
    } t_hdr;

    typedef struct {
        logic [DIFF_W-1:0] diff;
        logic              clamp;
    } t_nd;

    typedef struct {
        bit                mode;
        bit                dyn;
        logic [LEN_W-1:0]  len;
        logic [SPAN_W-1:0] span;
        t_hdr              h;
        bit                uncle;
        bit                typed;
        t_nd               e;
    } t_row;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
    logic [DW-1:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
    logic [DIFF_W-1:0] m_axis_tdata;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SPAN_W-1:0] i_cfg_data;

    bit                cur_mode, cur_dyn;
    logic [LEN_W-1:0]  cur_len;
    logic [SPAN_W-1:0] cur_span;

    t_nd next_q[$];
    int  errors, beats_in, beats_out, idle_cyc;
    t_row rows[$];

    pow_difficulty_retarget i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [DIFF_W-1:0] sat128(logic [127:0] v);
        return (v > 128'(DIFF_MAX)) ? DIFF_MAX : v[DIFF_W-1:0];
    endfunction

    function automatic t_nd calc_next_difficulty(t_hdr h, bit uncle);
        t_nd r;
        logic [TW-1:0]  s, t, gap;
        logic [63:0]    q, m;
        logic [DIFF_W-1:0] scaled;
        r.clamp = 1'b0;
        t = cur_span;
        if (h.height == 0) begin
            r.diff = ONE_Q;
        end else if (!cur_mode) begin
            if (cur_len == 0 || (h.height % cur_len) != 0 || h.height < cur_len) begin
                r.diff = h.diff;
            end else begin
                if (h.tip <= h.start) begin
                    r.clamp = 1'b1;
                    scaled = (h.tip == h.start) ? sat128(128'(h.diff) << 2) : h.diff >> 2;
                end else begin
                    s = h.tip - h.start;
                    if (t != 0 && s <= ((t - 40'd1) >> 2)) begin
                        r.clamp = 1'b1;
                        scaled = sat128(128'(h.diff) << 2);
                    end else if (t <= ((s - 40'd1) >> 2)) begin
                        r.clamp = 1'b1;
                        scaled = h.diff >> 2;
                    end else begin
                        scaled = sat128((128'(h.diff) * 128'(t)) / 128'(s));
                    end
                end
                r.diff = cur_dyn ? scaled : ONE_Q;
            end
        end else begin
            if (h.tip >= h.parent) begin
                gap = h.tip - h.parent;
                q = 64'(gap) / 64'd10000;
                m = (q >= 64'd100) ? 64'd1949 : 64'd2049 - q;
            end else begin
                gap = h.parent - h.tip;
                q = 64'(gap) / 64'd10000;
                m = 64'd2049 + q;
            end
            m = m + 64'(uncle);
            r.diff = sat128((128'(h.diff) * 128'(m)) >> 11);
            if (r.diff < MIN_Q) r.diff = MIN_Q;
        end
        return r;
    endfunction

    task automatic report(string what, logic [DIFF_W-1:0] got, logic [DIFF_W-1:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic add_row(t_row r);
        rows.insert(rows.size(), r);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    task automatic send_header(t_hdr h, bit uncle, bit typed, t_nd e);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= h;
        s_axis_tuser  <= uncle;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        next_q.insert(next_q.size(), typed ? e : calc_next_difficulty(h, uncle));
        beats_in++;
    endtask

    task automatic idle_sender(int g);
        if (g > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (next_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [SPAN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    task automatic apply_cfg(bit mode, bit dyn, logic [LEN_W-1:0] len, logic [SPAN_W-1:0] span);
        drain();
        write_reg(CFG_MODE, SPAN_W'(mode));
        write_reg(CFG_DYN, SPAN_W'(dyn));
        write_reg(CFG_LEN, SPAN_W'(len));
        write_reg(CFG_SPAN, span);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = mode;
        cur_dyn  = dyn;
        cur_len  = len;
        cur_span = span;
    endtask

    function automatic t_row mk(bit mode, bit dyn, logic [LEN_W-1:0] len,
                                logic [SPAN_W-1:0] span, logic [31:0] ht,
                                logic [TW-1:0] tip, logic [DIFF_W-1:0] diff,
                                logic [TW-1:0] start, logic [TW-1:0] parent,
                                bit uncle, bit typed, logic [DIFF_W-1:0] ed, bit ec);
        t_row r;
        r.mode = mode; r.dyn = dyn; r.len = len; r.span = span;
        r.h = '{parent: parent, start: start, diff: diff, tip: tip, height: ht};
        r.uncle = uncle; r.typed = typed;
        r.e.diff = ed; r.e.clamp = ec;
        return r;
    endfunction

    function automatic logic [TW-1:0] rnd40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [DIFF_W-1:0] rnd_diff();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return {16'($urandom), 32'($urandom)};
        if (r < 7) return 48'($urandom_range(0, 32'h0fff_ffff));
        if (r < 8) return DIFF_MAX;
        return ONE_Q + 48'($urandom_range(0, 32'h01ff_ffff)) - 48'h0100_0000;
    endfunction

    function automatic t_hdr rnd_header();
        t_hdr h;
        logic [TW-1:0] s;
        int r;
        h.diff = rnd_diff();
        h.tip  = rnd40();
        r = $urandom_range(0, 9);
        if (r == 0) h.height = 0;
        else if (r < 3 || cur_len == 0 || cur_mode) h.height = $urandom;
        else h.height = 32'(cur_len) * 32'($urandom_range(1, 50));
        r = $urandom_range(0, 9);
        if (r < 6) s = TW'((64'(cur_span) * 64'($urandom_range(1, 40))) / 64'd8);
        else if (r < 7) s = 40'($urandom_range(0, 3));
        else if (r < 8) s = -40'($urandom_range(1, 1000));
        else s = rnd40();
        h.start = h.tip - s;
        r = $urandom_range(0, 9);
        if (r < 6) h.parent = h.tip - 40'($urandom_range(0, 1200000));
        else if (r < 8) h.parent = h.tip + 40'($urandom_range(0, 200000));
        else h.parent = rnd40();
        return h;
    endfunction

    // receiver: bursts of ready, random gaps, one long hold-off
    initial begin
        int g;
        bit held;
        held = 0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(negedge i_clk);
            if (!held && beats_out > 400) begin
                held = 1;
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (HOLD - 1) @(negedge i_clk);
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    @(negedge i_clk);
                    m_axis_tready <= 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_nd e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (next_q.size() == 0) begin
                report("unexpected beat", m_axis_tdata, '0);
            end else begin
                e = next_q.pop_front();
                if (m_axis_tdata !== e.diff) report("next_difficulty", m_axis_tdata, e.diff);
                if (m_axis_tuser !== e.clamp)
                    report("ratio_clamped", 48'(m_axis_tuser), 48'(e.clamp));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cyc = 0;
        else idle_cyc++;
        if (idle_cyc >= LIMIT) begin
            $display("watchdog: no beat for %0d cycles", LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        bit nogap;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_MODE; i_cfg_data = '0;
        errors = 0; beats_in = 0; beats_out = 0; idle_cyc = 0;
        cur_mode = 0; cur_dyn = 1; cur_len = 16'd2016; cur_span = RSPAN;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // mode, dyn, len, span, height, tip, diff, start, parent, uncle, typed, exp
        add_row(mk(0,1,2016,RSPAN, 0, 77, 48'h123, 5, 3, 1, 1, ONE_Q, 0));
        add_row(mk(0,1,2016,RSPAN, 5, 900, 48'd123456, 1, 0, 0, 1, 48'd123456, 0));
        add_row(mk(0,1,2016,RSPAN, 2016, 1000, DIFF_MAX, 1000, 0, 0, 1, DIFF_MAX, 1));
        add_row(mk(0,1,2016,RSPAN, 2016, 1000, DIFF_MAX, 2000, 0, 0, 1,
                   DIFF_MAX >> 2, 1));
        add_row(mk(0,1,2016,RSPAN, 2016, RSPAN+5, ONE_Q, 5, 0, 0, 1, ONE_Q, 0));
        add_row(mk(0,1,2016,RSPAN, 4032, 2*RSPAN, 48'h3_0000_0001, 0, 0, 0, 0, '0, 0));
        add_row(mk(0,1,2016,RSPAN, 2016, RSPAN/8, 48'h5555, 0, 0, 0, 0, '0, 0));
        add_row(mk(0,1,2016,RSPAN, 2016, 8*RSPAN, 48'h5555, 0, 0, 0, 0, '0, 0));
        add_row(mk(0,1,2016,RSPAN, 32'hffff_ffff, TMAX, 48'hab_cdef, 0, TMAX, 1, 1,
                   48'hab_cdef, 0));
        add_row(mk(0,1,0,RSPAN, 2016, 10, 48'd777, 5, 0, 0, 1, 48'd777, 0));
        add_row(mk(0,1,1,RSPAN, 1, TMAX, DIFF_MAX, 0, 0, 0, 0, '0, 0));
        add_row(mk(0,1,2016,0, 2016, 10, 48'd1000, 5, 0, 0, 1, 48'd250, 1));
        add_row(mk(0,1,2016,0, 2016, 10, 48'd5, 10, 0, 0, 1, 48'd20, 1));
        add_row(mk(0,0,2016,RSPAN, 2016, 10, 48'd99, 10, 0, 0, 1, ONE_Q, 1));
        add_row(mk(0,0,2016,RSPAN, 2016, RSPAN, 48'd99, 0, 0, 0, 1, ONE_Q, 0));
        add_row(mk(0,1,16'hffff,TMAX, 65535, TMAX, DIFF_MAX, 1, 0, 0, 0, '0, 0));
        add_row(mk(1,1,2016,RSPAN, 0, 5, 48'd9, 0, 0, 1, 1, ONE_Q, 0));
        add_row(mk(1,1,2016,RSPAN, 7, 500, 48'h8_0000_0000, 0, 500, 0, 0, '0, 0));
        add_row(mk(1,1,2016,RSPAN, 7, 9999, ONE_Q, 0, 0, 1, 0, '0, 0));
        add_row(mk(1,1,2016,RSPAN, 7, TMAX, 48'd0, 0, 0, 0, 1, MIN_Q, 0));
        add_row(mk(1,1,2016,RSPAN, 7, 0, DIFF_MAX, 0, TMAX, 1, 1, DIFF_MAX, 0));
        add_row(mk(1,1,2016,RSPAN, 7, 1, DIFF_MAX, 0, 1, 0, 1, DIFF_MAX, 0));
        add_row(mk(1,1,2016,RSPAN, 7, 990000, ONE_Q, 0, 0, 0, 0, '0, 0));
        add_row(mk(1,1,2016,RSPAN, 7, 1000000, ONE_Q, 0, 0, 1, 0, '0, 0));

        foreach (rows[i]) begin
            if (rows[i].mode != cur_mode || rows[i].dyn != cur_dyn ||
                rows[i].len != cur_len || rows[i].span != cur_span)
                apply_cfg(rows[i].mode, rows[i].dyn, rows[i].len, rows[i].span);
            send_header(rows[i].h, rows[i].uncle, rows[i].typed, rows[i].e);
            idle_sender(pick_gap());
        end

        for (int p = 0; p < PHASES; p++) begin
            logic [LEN_W-1:0]  len;
            logic [SPAN_W-1:0] span;
            t_nd none;
            none = '{diff: '0, clamp: 1'b0};
            case (p % 5)
                0: len = 16'd1;
                1: len = 16'hffff;
                2: len = 16'd0;
                3: len = 16'($urandom_range(2, 16));
                default: len = 16'd2016;
            endcase
            case (p % 3)
                0: span = 40'd1;
                1: span = TMAX;
                default: span = 40'($urandom_range(1000, 32'h4000_0000));
            endcase
            if (p == 7) span = 40'd0;
            apply_cfg(p[0], (p % 4) != 2, len, span);
            nogap = (p % 3) == 1;
            for (int k = 0; k < PER_PH; k++) begin
                send_header(rnd_header(), $urandom_range(0, 1), 1'b0, none);
                if (!nogap) idle_sender(pick_gap());
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        $display("covered %0d header beats in, %0d results out, directed table and %0d phases",
                 beats_in, beats_out, PHASES);
        $display("both modes, static epoch, zero/extreme lengths and spans, one long stall");
        if (errors == 0 && next_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
